// ----- rtl/complex_linear_convolution_unit_assert.svh -----
// Assertion macros used by the checker file of the convolution unit.
`ifndef COMPLEX_LINEAR_CONVOLUTION_UNIT_ASSERT_SVH
`define COMPLEX_LINEAR_CONVOLUTION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CLCU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clcu: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define CLCU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clcu: next-cycle check failed");

`endif

// ----- rtl/clcu_pkg.sv -----
// Types and constants shared by the complex convolution unit.
package clcu_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WORD_W      = 2 * SAMPLE_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    localparam t_sample SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Request kind.
    typedef enum logic {
        FUNC_TAP = 1'b0,
        FUNC_SRC = 1'b1
    } t_func;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // Control from the sequencer to the shared multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic issue;
        logic hist_ok;
    } t_mac_ctl;

endpackage

// ----- rtl/clcu_src_if.sv -----
// Input channel: tap loads and source samples.
interface clcu_src_if import clcu_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    func;
    t_sample sample_re;
    t_sample sample_im;
    logic    is_last;

    modport source (output valid, func, sample_re, sample_im, is_last, input ready);
    modport sink   (input valid, func, sample_re, sample_im, is_last, output ready);
endinterface

// ----- rtl/clcu_res_if.sv -----
// Output channel: convolution result samples.
interface clcu_res_if import clcu_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample out_re;
    t_sample out_im;
    logic    clipped;
    logic    out_last;

    modport source (output valid, out_re, out_im, clipped, out_last, input ready);
    modport sink   (input valid, out_re, out_im, clipped, out_last, output ready);
endinterface

// ----- rtl/clcu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module clcu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/clcu_cmac.sv -----
// Shared complex multiply-accumulate unit with rounding and saturation.
module clcu_cmac import clcu_pkg::*; #(
    parameter int MAX_TAPS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_ctl          i_ctl,
    input  logic [WORD_W-1:0] i_tap,
    input  logic [WORD_W-1:0] i_hist,
    output logic              o_busy,
    output t_sample           o_re,
    output t_sample           o_im,
    output logic              o_clip
);

    localparam int ACC_W = 2 * SAMPLE_BITS + 2 + $clog2(MAX_TAPS);
    localparam int PRD_W = 2 * SAMPLE_BITS;
    localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << SAMPLE_BITS;
    localparam logic signed [ACC_W-1:0] MAXE = ACC_W'(2**(SAMPLE_BITS-1) - 1);
    localparam logic signed [ACC_W-1:0] MINE = ACC_W'(-(2**(SAMPLE_BITS-1)));

    logic                    r_v1;
    logic                    r_ok1;
    logic                    r_v2;
    logic signed [PRD_W-1:0] r_p_rr;
    logic signed [PRD_W-1:0] r_p_ii;
    logic signed [PRD_W-1:0] r_p_ri;
    logic signed [PRD_W-1:0] r_p_ir;
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;

    t_sample                 tap_re;
    t_sample                 tap_im;
    t_sample                 hist_re;
    t_sample                 hist_im;
    logic [SAMPLE_BITS:0]    fin_re;
    logic [SAMPLE_BITS:0]    fin_im;

    // Round half up, scale by a quarter back to Q1.15, saturate.
    function automatic logic [SAMPLE_BITS:0] finish(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] sh;
        logic [SAMPLE_BITS:0]    res;
        sh = (a + RND) >>> (SAMPLE_BITS + 1);
        if (sh > MAXE) begin
            res = {1'b1, SAT_MAX};
        end else if (sh < MINE) begin
            res = {1'b1, SAT_MIN};
        end else begin
            res = {1'b0, sh[SAMPLE_BITS-1:0]};
        end
        return res;
    endfunction

    // Split RAM words; drop history entries not written since the last clear
    always_comb begin
        tap_re  = i_tap[WORD_W-1 -: SAMPLE_BITS];
        tap_im  = i_tap[SAMPLE_BITS-1:0];
        hist_re = r_ok1 ? t_sample'(i_hist[WORD_W-1 -: SAMPLE_BITS]) : '0;
        hist_im = r_ok1 ? t_sample'(i_hist[SAMPLE_BITS-1:0]) : '0;
    end

    // Track operands in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        r_ok1 <= i_ctl.hist_ok;
        if (r_v1) begin
            r_p_rr <= tap_re * hist_re;
            r_p_ii <= tap_im * hist_im;
            r_p_ri <= tap_re * hist_im;
            r_p_ir <= tap_im * hist_re;
        end
    end

    // Accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v2) begin
            r_acc_re <= r_acc_re + ACC_W'(r_p_rr) - ACC_W'(r_p_ii);
            r_acc_im <= r_acc_im + ACC_W'(r_p_ri) + ACC_W'(r_p_ir);
        end
    end

    assign fin_re = finish(r_acc_re);
    assign fin_im = finish(r_acc_im);
    assign o_re   = fin_re[SAMPLE_BITS-1:0];
    assign o_im   = fin_im[SAMPLE_BITS-1:0];
    assign o_clip = fin_re[SAMPLE_BITS] | fin_im[SAMPLE_BITS];
    assign o_busy = r_v1 | r_v2;

endmodule

// ----- rtl/complex_linear_convolution_unit.sv -----
// Complex linear convolution: one shared complex MAC walks the loaded taps per output.
// Tap load request: accepted while idle, no result. Source request: each output runs one
// history write, tap_count MAC issues, a pipeline drain until the MAC is idle and a finish
// that waits for room in the output register; the input stays not ready meanwhile. A final
// sample adds tap_count - 1 tail outputs. Results sit in an output register.
// Reset clears control state; history reads as zero through a fill count, taps are undefined.
module complex_linear_convolution_unit import clcu_pkg::*; #(
    parameter int MAX_TAPS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    clcu_src_if.sink  i_src,
    clcu_res_if.source o_res
);

    localparam int PTR_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_TAPS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_TAPS - 1);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_tap_count, n_tap_count;
    logic [CNT_W-1:0]  r_load_idx, n_load_idx;
    logic              r_taps_done, n_taps_done;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [PTR_W-1:0]  r_hidx, n_hidx;
    logic [CNT_W-1:0]  r_tail_left, n_tail_left;
    logic              r_last, n_last;
    logic [WORD_W-1:0] r_x, n_x;
    logic              r_out_valid, n_out_valid;
    t_sample           r_out_re, n_out_re;
    t_sample           r_out_im, n_out_im;
    logic              r_out_clip, n_out_clip;
    logic              r_out_last, n_out_last;

    logic              src_acc;
    logic              src_tap;
    logic              src_smp;
    logic [CNT_W-1:0]  load_eff;
    logic              tap_we;
    logic              hist_we;
    logic              out_load;
    t_mac_ctl          mac_ctl;
    logic [WORD_W-1:0] tap_rd;
    logic [WORD_W-1:0] hist_rd;
    logic              mac_busy;
    t_sample           mac_re;
    t_sample           mac_im;
    logic              mac_clip;

    assign src_acc  = i_src.valid && i_src.ready;
    assign src_tap  = src_acc && (i_src.func == FUNC_TAP);
    assign src_smp  = src_acc && (i_src.func == FUNC_SRC);
    // A tap arriving after a closed set starts a new set at index zero
    assign load_eff = r_taps_done ? '0 : r_load_idx;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (src_smp) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_MAC;
            end
            ST_MAC: begin
                if (r_k == r_tap_count) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mac_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_state = (r_tail_left != '0) ? ST_WRITE : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_src.ready     = (r_state == ST_IDLE);
        tap_we          = src_tap && (load_eff < CNT_MAX);
        hist_we         = (r_state == ST_WRITE);
        mac_ctl.clear   = (r_state == ST_WRITE);
        mac_ctl.issue   = (r_state == ST_MAC) && (r_k != r_tap_count);
        mac_ctl.hist_ok = (r_k < r_fill);
        out_load        = (r_state == ST_FINISH) && (!r_out_valid || o_res.ready);
    end

    // Datapath next values
    always_comb begin
        n_tap_count = r_tap_count;
        n_load_idx  = r_load_idx;
        n_taps_done = r_taps_done;
        n_ptr       = r_ptr;
        n_fill      = r_fill;
        n_k         = r_k;
        n_hidx      = r_hidx;
        n_tail_left = r_tail_left;
        n_last      = r_last;
        n_x         = r_x;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_re    = r_out_re;
        n_out_im    = r_out_im;
        n_out_clip  = r_out_clip;
        n_out_last  = r_out_last;

        // Load a tap; drop taps past the store but still close the set
        if (src_tap) begin
            if (load_eff < CNT_MAX) begin
                n_load_idx  = load_eff + CNT_W'(1);
                n_tap_count = load_eff + CNT_W'(1);
            end else begin
                n_load_idx  = load_eff;
            end
            n_taps_done = i_src.is_last;
        end

        // Capture a source sample and its tail length
        if (src_smp) begin
            n_x         = {i_src.sample_re, i_src.sample_im};
            n_last      = i_src.is_last;
            n_tail_left = (i_src.is_last && r_tap_count != '0) ?
                          r_tap_count - CNT_W'(1) : '0;
        end

        // Write history, start the tap walk at the newest sample
        if (r_state == ST_WRITE) begin
            n_fill = (r_fill == CNT_MAX) ? r_fill : r_fill + CNT_W'(1);
            n_k    = '0;
            n_hidx = r_ptr;
        end

        // Advance to the next tap and the next older sample
        if (mac_ctl.issue) begin
            n_k    = r_k + CNT_W'(1);
            n_hidx = (r_hidx == '0) ? PTR_LAST : r_hidx - PTR_W'(1);
        end

        // Hand off the result, advance the pointer, feed a zero for the tail
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_re    = mac_re;
            n_out_im    = mac_im;
            n_out_clip  = mac_clip;
            n_out_last  = r_last && (r_tail_left == '0);
            n_ptr       = (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);
            if (r_tail_left != '0) begin
                n_tail_left = r_tail_left - CNT_W'(1);
                n_x         = '0;
            end else if (r_last) begin
                n_ptr  = '0;
                n_fill = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap_count <= '0;
            r_load_idx  <= '0;
            r_taps_done <= 1'b1;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_hidx      <= '0;
            r_tail_left <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tap_count <= n_tap_count;
            r_load_idx  <= n_load_idx;
            r_taps_done <= n_taps_done;
            r_ptr       <= n_ptr;
            r_fill      <= n_fill;
            r_k         <= n_k;
            r_hidx      <= n_hidx;
            r_tail_left <= n_tail_left;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_out_re   <= n_out_re;
        r_out_im   <= n_out_im;
        r_out_clip <= n_out_clip;
        r_out_last <= n_out_last;
    end

    // Tap store
    clcu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tap_we),
        .i_wr_addr (load_eff[PTR_W-1:0]),
        .i_wr_data ({i_src.sample_re, i_src.sample_im}),
        .i_rd_en   (mac_ctl.issue),
        .i_rd_addr (r_k[PTR_W-1:0]),
        .o_rd_data (tap_rd)
    );

    // Sample history ring
    clcu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hist_we),
        .i_wr_addr (r_ptr),
        .i_wr_data (r_x),
        .i_rd_en   (mac_ctl.issue),
        .i_rd_addr (r_hidx),
        .o_rd_data (hist_rd)
    );

    // Shared complex MAC
    clcu_cmac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_cmac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_tap   (tap_rd),
        .i_hist  (hist_rd),
        .o_busy  (mac_busy),
        .o_re    (mac_re),
        .o_im    (mac_im),
        .o_clip  (mac_clip)
    );

    assign o_res.valid    = r_out_valid;
    assign o_res.out_re   = r_out_re;
    assign o_res.out_im   = r_out_im;
    assign o_res.clipped  = r_out_clip;
    assign o_res.out_last = r_out_last;

endmodule

// ----- rtl/clcu_checker.sv -----
// Port-level checker for the convolution unit and its bind.
`include "complex_linear_convolution_unit_assert.svh"

module clcu_checker import clcu_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_in_func,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_sample i_out_re,
    input t_sample i_out_im,
    input logic    i_out_clipped,
    input logic    i_out_last
);

    // Hold a stalled result
    `CLCU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_re) && $stable(i_out_im) && $stable(i_out_clipped) && $stable(i_out_last))

    // A source request keeps the unit busy on the next cycle
    `CLCU_ASSERT_NXT(a_src_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_func == FUNC_SRC), !i_in_ready)

    // A clipped result carries a saturated part
    `CLCU_ASSERT_IMP(a_clip_sat, i_clk, i_rst_n, i_out_valid && i_out_clipped, (i_out_re == SAT_MAX) || (i_out_re == SAT_MIN) || (i_out_im == SAT_MAX) || (i_out_im == SAT_MIN))

    // A tap load never brings up a result
    `CLCU_ASSERT_NXT(a_tap_quiet, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_func == FUNC_TAP) && !i_out_valid, !i_out_valid)

endmodule

bind complex_linear_convolution_unit clcu_checker u_clcu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_src.valid),
    .i_in_ready    (i_src.ready),
    .i_in_func     (i_src.func),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_re      (o_res.out_re),
    .i_out_im      (o_res.out_im),
    .i_out_clipped (o_res.clipped),
    .i_out_last    (o_res.out_last)
);
